FILE: src/miss_holding_table_top_assert.svh
// assertion macros shared by the miss holding table rtl
`ifndef MISS_HOLDING_TABLE_TOP_ASSERT_SVH
`define MISS_HOLDING_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mht_pkg.sv
package mht_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 32;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_REMAP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_HELD_FULL  = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_DELETED    = 3'd3,
    ST_DELETE_MISS = 3'd4,
    ST_REMAPPED   = 3'd5,
    ST_REMAP_MISS = 3'd6
  } status_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic                 del;
    logic                 remap;
    logic                 ins;
    logic [ADDR_BITS-1:0] key;
    logic [ADDR_BITS-1:0] new_addr;
    logic [ADDR_BITS-1:0] ins_addr;
    logic [TIME_W-1:0]    ins_start;
    logic [CNT_W-1:0]     count;
  } cell_cmd_t;

endpackage

FILE: src/mht_cell.sv
module mht_cell (
  input  logic                          clk,
  input  logic [mht_pkg::IDX_W-1:0]     idx,
  input  mht_pkg::cell_cmd_t            cmd,
  input  logic [mht_pkg::CNT_W-1:0]     ins_pos,
  input  logic                          hit_in,
  output logic                          hit_out,
  input  logic [mht_pkg::ADDR_BITS-1:0] nb_addr,
  input  logic [mht_pkg::TIME_W-1:0]    nb_start,
  output logic [mht_pkg::ADDR_BITS-1:0] addr,
  output logic [mht_pkg::TIME_W-1:0]    start,
  output logic [mht_pkg::TIME_W-1:0]    sel_start
);

  logic                          valid;
  logic                          match;
  logic                          first;
  logic [mht_pkg::ADDR_BITS-1:0] addr_next;
  logic [mht_pkg::TIME_W-1:0]    start_next;

  assign valid     = mht_pkg::CNT_W'(idx) < cmd.count;
  assign match     = valid && (addr == cmd.key);
  // oldest match: no match further toward the head of the chain
  assign first     = match && !hit_in;
  assign hit_out   = hit_in || match;
  assign sel_start = first ? start : '0;

  always_comb begin
    addr_next  = addr;
    start_next = start;
    if (cmd.ins && (mht_pkg::CNT_W'(idx) == ins_pos)) begin
      addr_next  = cmd.ins_addr;
      start_next = cmd.ins_start;
    end else if (cmd.del && hit_out) begin
      // compaction: everything from the removed entry on moves up one
      addr_next  = nb_addr;
      start_next = nb_start;
    end else if (cmd.remap && first) begin
      addr_next  = cmd.new_addr;
    end
  end

  always_ff @(posedge clk) begin
    addr  <= addr_next;
    start <= start_next;
  end

endmodule

FILE: src/miss_holding_table_top.sv
// one item in flight: accepted, then executed against the cell chain when the
// output register is empty or not stalled; the result is registered there
// in_stall stays high while the capture register is full
// an input is taken while the previous result still waits in the output register
// reset (rst, synchronous): empty table, nothing held, stall total zero
module miss_holding_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] new_address,
  input  logic        is_writeback,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] latency,
  output logic [4:0]  occupancy,
  output logic        replayed,
  output logic        held,
  output logic [31:0] stall_total
);

  localparam int N = mht_pkg::ENTRIES;
  localparam int AW = mht_pkg::ADDR_BITS;
  localparam int TW = mht_pkg::TIME_W;
  localparam int CW = mht_pkg::CNT_W;

  // captured item
  logic          pend;
  mht_pkg::cmd_t cmd_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] naddr_q;
  logic          wb_q;
  logic [TW-1:0] now_q;

  // table control state
  logic [CW-1:0] count;
  logic          holding;
  logic [AW-1:0] held_addr;
  logic          held_wb;
  logic [TW-1:0] full_since;
  logic [TW-1:0] stall_sum;

  logic          exec;
  logic          in_xfer;

  logic [CW-1:0]     count_next;
  logic              holding_next;
  logic              hold_load;
  logic [TW-1:0]     full_since_next;
  logic [TW-1:0]     stall_sum_next;
  mht_pkg::status_t  status_next;
  logic [TW-1:0]     latency_next;
  logic              replayed_next;
  logic [CW-1:0]     after_del;

  mht_pkg::cell_cmd_t ccmd;
  logic [CW-1:0]      ins_pos;

  logic [N:0]    hit;
  logic [AW-1:0] cell_addr  [N];
  logic [TW-1:0] cell_start [N];
  logic [TW-1:0] cell_sel   [N];
  logic [TW-1:0] found_start;
  logic          found;

  assign in_stall = pend;
  assign in_xfer  = in_valid && !in_stall;
  assign exec     = pend && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_xfer) begin
      pend <= 1'b1;
    end else if (exec) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q   <= mht_pkg::cmd_t'(command);
      addr_q  <= address[AW-1:0];
      naddr_q <= new_address[AW-1:0];
      wb_q    <= is_writeback;
      now_q   <= now;
    end
  end

  // the cell chain
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [AW-1:0] nb_addr;
    logic [TW-1:0] nb_start;

    if (i == N - 1) begin : g_tail
      assign nb_addr  = '0;
      assign nb_start = '0;
    end else begin : g_link
      assign nb_addr  = cell_addr[i+1];
      assign nb_start = cell_start[i+1];
    end

    mht_cell u_cell (
      .clk       (clk),
      .idx       (mht_pkg::IDX_W'(i)),
      .cmd       (ccmd),
      .ins_pos   (ins_pos),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .nb_addr   (nb_addr),
      .nb_start  (nb_start),
      .addr      (cell_addr[i]),
      .start     (cell_start[i]),
      .sel_start (cell_sel[i])
    );
  end

  assign found = hit[N];

  always_comb begin
    found_start = '0;
    for (int i = 0; i < N; i++) begin
      found_start = found_start | cell_sel[i];
    end
  end

  assign after_del = found ? (count - CW'(1)) : count;

  always_comb begin
    ccmd.del       = 1'b0;
    ccmd.remap     = 1'b0;
    ccmd.ins       = 1'b0;
    ccmd.key       = addr_q;
    ccmd.new_addr  = naddr_q;
    ccmd.ins_addr  = addr_q;
    ccmd.ins_start = now_q;
    ccmd.count     = count;
    ins_pos         = count;
    count_next      = count;
    holding_next    = holding;
    hold_load       = 1'b0;
    full_since_next = full_since;
    stall_sum_next  = stall_sum;
    status_next     = mht_pkg::ST_REJECTED;
    latency_next    = '0;
    replayed_next   = 1'b0;

    case (cmd_q)
      mht_pkg::CMD_INSERT: begin
        if (holding) begin
          status_next = mht_pkg::ST_REJECTED;
        end else if (count < CW'(N)) begin
          status_next = mht_pkg::ST_STORED;
          ccmd.ins    = exec && !wb_q;
          if (!wb_q) begin
            count_next = count + CW'(1);
          end
        end else begin
          status_next     = mht_pkg::ST_HELD_FULL;
          holding_next    = 1'b1;
          hold_load       = 1'b1;
          full_since_next = now_q;
        end
      end
      mht_pkg::CMD_DELETE: begin
        ccmd.del   = exec;
        count_next = after_del;
        if (found) begin
          status_next  = mht_pkg::ST_DELETED;
          latency_next = now_q - found_start;
        end else begin
          status_next = mht_pkg::ST_DELETE_MISS;
        end
        if (holding) begin
          stall_sum_next = stall_sum + (now_q - full_since);
          if (after_del < CW'(N)) begin
            holding_next   = 1'b0;
            replayed_next  = 1'b1;
            ins_pos        = after_del;
            ccmd.ins_addr  = held_addr;
            ccmd.ins       = exec && !held_wb;
            if (!held_wb) begin
              count_next = after_del + CW'(1);
            end
          end else begin
            full_since_next = now_q;
          end
        end
      end
      mht_pkg::CMD_REMAP: begin
        ccmd.remap  = exec;
        status_next = found ? mht_pkg::ST_REMAPPED : mht_pkg::ST_REMAP_MISS;
      end
      default: begin
        status_next = mht_pkg::ST_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      holding    <= 1'b0;
      held_wb    <= 1'b0;
      full_since <= '0;
      stall_sum  <= '0;
    end else if (exec) begin
      count      <= count_next;
      holding    <= holding_next;
      full_since <= full_since_next;
      stall_sum  <= stall_sum_next;
      if (hold_load) begin
        held_wb <= wb_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && hold_load) begin
      held_addr <= addr_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status      <= status_next;
      latency     <= latency_next;
      occupancy   <= 5'(count_next);
      replayed    <= replayed_next;
      held        <= holding_next;
      stall_total <= stall_sum_next;
    end
  end

`include "miss_holding_table_top_assert.svh"

  `MHT_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(N), "entry count beyond table size")
  `MHT_ASSERT_NOW(a_hold_full, holding, count == CW'(N), "request held while table has room")
  `MHT_ASSERT_NEXT(a_exec_result, exec, out_valid, "executed item left no result")
  `MHT_ASSERT_NOW(a_replay_clear, out_valid && replayed, !held, "replay reported with request held")

endmodule
